@@ rtl/hbd_pkg.sv @@
package hbd_pkg;

   // Default sample and coefficient widths.
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEFF_BITS_DEF  = 16;

   // Filter structure: four folded tap pairs, an eight-deep odd delay line
   // and a four-deep even delay line whose oldest entry is the center tap.
   localparam int TAPS       = 4;
   localparam int ODD_DEPTH  = 2 * TAPS;
   localparam int EVEN_DEPTH = TAPS;

   // Register port geometry.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register index map (byte address is four times the index).
   typedef enum logic [1:0] {
      REG_COEFF_OUTER  = 2'd0,
      REG_COEFF_SECOND = 2'd1,
      REG_COEFF_THIRD  = 2'd2,
      REG_COEFF_INNER  = 2'd3
   } hbd_reg_type;

   // Flow control handed from the top level to the arithmetic stage.
   typedef struct packed {
      logic stage_valid;
      logic rsp_stall;
   } hbd_flow_type;

endpackage

@@ rtl/hbd_csr.sv @@
module hbd_csr #(
   parameter int COEFF_BITS = hbd_pkg::COEFF_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hbd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [hbd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [hbd_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic signed [COEFF_BITS-1:0]         coeff [hbd_pkg::TAPS]
);
   import hbd_pkg::*;

   logic signed [COEFF_BITS-1:0] coeff_ff [TAPS];
   logic signed [COEFF_BITS-1:0] coeff_in [TAPS];
   hbd_reg_type                  reg_sel;
   logic                         wr_en;

   // Word address selects the register; the low two bits are the byte offset.
   assign reg_sel = hbd_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   // Coefficient write decode.
   always_comb begin
      coeff_in = coeff_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_COEFF_OUTER:  coeff_in[0] = csr_pwdata[COEFF_BITS-1:0];
            REG_COEFF_SECOND: coeff_in[1] = csr_pwdata[COEFF_BITS-1:0];
            REG_COEFF_THIRD:  coeff_in[2] = csr_pwdata[COEFF_BITS-1:0];
            REG_COEFF_INNER:  coeff_in[3] = csr_pwdata[COEFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   // Read data returns the coefficient sign-extended to the bus width.
   always_comb begin
      case (reg_sel)
         REG_COEFF_OUTER:  csr_prdata = CSR_DATA_BITS'(coeff_ff[0]);
         REG_COEFF_SECOND: csr_prdata = CSR_DATA_BITS'(coeff_ff[1]);
         REG_COEFF_THIRD:  csr_prdata = CSR_DATA_BITS'(coeff_ff[2]);
         REG_COEFF_INNER:  csr_prdata = CSR_DATA_BITS'(coeff_ff[3]);
         default:          csr_prdata = '0;
      endcase
   end

   assign coeff = coeff_ff;

endmodule

@@ rtl/hbd_window.sv @@
module hbd_window #(
   parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] even_sample,
   input  logic signed [SAMPLE_BITS-1:0] odd_sample,
   output logic signed [SAMPLE_BITS-1:0] even_center,
   output logic signed [SAMPLE_BITS-1:0] odd_tap [hbd_pkg::ODD_DEPTH]
);
   import hbd_pkg::*;

   logic signed [SAMPLE_BITS-1:0] even_ff [EVEN_DEPTH];
   logic signed [SAMPLE_BITS-1:0] even_in [EVEN_DEPTH];
   logic signed [SAMPLE_BITS-1:0] odd_ff  [ODD_DEPTH];
   logic signed [SAMPLE_BITS-1:0] odd_in  [ODD_DEPTH];

   // Both delay lines shift by one when an item is loaded; entry 0 is newest.
   always_comb begin
      even_in[0] = even_sample;
      for (int i = 1; i < EVEN_DEPTH; i++) begin
         even_in[i] = even_ff[i-1];
      end
      odd_in[0] = odd_sample;
      for (int i = 1; i < ODD_DEPTH; i++) begin
         odd_in[i] = odd_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EVEN_DEPTH; i++) begin
            even_ff[i] <= '0;
         end
         for (int i = 0; i < ODD_DEPTH; i++) begin
            odd_ff[i] <= '0;
         end
      end else if (load) begin
         even_ff <= even_in;
         odd_ff  <= odd_in;
      end
   end

   // The oldest even sample is the center tap.
   assign even_center = even_ff[EVEN_DEPTH-1];
   assign odd_tap     = odd_ff;

endmodule

@@ rtl/hbd_mac.sv @@
module hbd_mac #(
   parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = hbd_pkg::COEFF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hbd_pkg::hbd_flow_type         flow,
   input  logic signed [SAMPLE_BITS-1:0] even_center,
   input  logic signed [SAMPLE_BITS-1:0] odd_tap [hbd_pkg::ODD_DEPTH],
   input  logic signed [COEFF_BITS-1:0]  coeff   [hbd_pkg::TAPS],
   output logic                          out_ready,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS+1:0] rsp_filtered_sample
);
   import hbd_pkg::*;

   localparam int FRAC_BITS = COEFF_BITS - 2;
   localparam int PRE_W     = SAMPLE_BITS + 1;
   localparam int PROD_W    = PRE_W + COEFF_BITS;
   localparam int ACC_W     = SAMPLE_BITS + COEFF_BITS + 4;
   localparam int SH_W      = ACC_W - FRAC_BITS;
   localparam int OUT_W     = SAMPLE_BITS + 2;
   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [PRE_W-1:0]  pre  [TAPS];
   logic signed [PROD_W-1:0] prod [TAPS];
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [SH_W-1:0]   shifted;
   logic signed [OUT_W-1:0]  sat;
   logic signed [OUT_W-1:0]  result_ff;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     advance;

   // Fold the symmetric taps, then one multiply per pair.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         pre[i]  = PRE_W'(odd_tap[i]) + PRE_W'(odd_tap[ODD_DEPTH-1-i]);
         prod[i] = PROD_W'(pre[i]) * PROD_W'(coeff[i]);
      end
   end

   // Exact sum with the unity center tap scaled up to the coefficient format.
   always_comb begin
      acc = ACC_W'(even_center) << FRAC_BITS;
      for (int i = 0; i < TAPS; i++) begin
         acc = acc + ACC_W'(prod[i]);
      end
   end

   // Round half up, drop the fraction, and clamp to the output range.
   assign rounded = acc + ROUND_HALF;
   assign shifted = $signed(rounded[ACC_W-1:FRAC_BITS]);

   always_comb begin
      if (shifted > SAT_HI) begin
         sat = SAT_HI[OUT_W-1:0];
      end else if (shifted < SAT_LO) begin
         sat = SAT_LO[OUT_W-1:0];
      end else begin
         sat = shifted[OUT_W-1:0];
      end
   end

   // Result register: loaded from a full window whenever it is empty or being taken.
   assign out_ready = !valid_ff || !flow.rsp_stall;
   assign advance   = flow.stage_valid && out_ready;
   assign valid_in  = advance || (valid_ff && flow.rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= sat;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_filtered_sample = result_ff;

endmodule

@@ rtl/halfband_decimator_15tap_unit.sv @@
// Folded 15-tap half-band decimator by two.
// Each item on the req_ channel carries one even and one odd sample; each
// accepted item yields exactly one filtered sample on the rsp_ channel.
// An item is taken when req_valid is high and req_stall is low, and a result
// is taken when rsp_valid is high and rsp_stall is low.
// An accepted item is first held in the window register; its result is then
// written to the result register when the output is free, and rsp_valid
// rises with it.
// Throughput: one item per cycle while rsp_stall is low. The path between
// the window register and the result register holds four pre-adds, four
// multipliers, the sum, the rounding and the saturation.
// When the receiver stalls, the result register holds its value and the
// window register can still take one more item; req_stall goes high only
// while both are full and rsp_stall is high.
// Coefficients sit at csr_ byte addresses 0, 4, 8 and 12 (outer, second, third,
// inner pair); users must write them only while no item is in flight (unchecked).
// Synchronous reset clears the delay lines and coefficients to zero and
// empties both registers; no clearing pass follows.
module halfband_decimator_15tap_unit #(
   parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = hbd_pkg::COEFF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_even_sample,
   input  logic signed [SAMPLE_BITS-1:0]      req_odd_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS+1:0]      rsp_filtered_sample,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hbd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import hbd_pkg::*;

   logic signed [COEFF_BITS-1:0]  coeff   [TAPS];
   logic signed [SAMPLE_BITS-1:0] even_center;
   logic signed [SAMPLE_BITS-1:0] odd_tap [ODD_DEPTH];
   logic                          stage_ff;
   logic                          stage_in;
   logic                          accept;
   logic                          out_ready;
   hbd_flow_type                  flow;

   assign csr_pready = 1'b1;

   // Coefficient registers.
   hbd_csr #(.COEFF_BITS(COEFF_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .coeff       (coeff)
   );

   // The window register holds one item; it frees when its result moves on.
   assign req_stall = stage_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign stage_in  = accept || (stage_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // Delay lines, shifted on each accepted item.
   hbd_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .even_sample (req_even_sample),
      .odd_sample  (req_odd_sample),
      .even_center (even_center),
      .odd_tap     (odd_tap)
   );

   // Arithmetic and result register.
   assign flow.stage_valid = stage_ff;
   assign flow.rsp_stall   = rsp_stall;

   hbd_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEFF_BITS  (COEFF_BITS)
   ) u_mac (
      .clock               (clock),
      .reset               (reset),
      .flow                (flow),
      .even_center         (even_center),
      .odd_tap             (odd_tap),
      .coeff               (coeff),
      .out_ready           (out_ready),
      .rsp_valid           (rsp_valid),
      .rsp_filtered_sample (rsp_filtered_sample)
   );

   // The input side stalls only with both registers full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_ff && rsp_valid && rsp_stall))
      else $error("input stalled while a register was free");

   // An accepted item always occupies the window register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_ff)
      else $error("accepted item lost from the window register");

   // A full window moving on always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      (stage_ff && out_ready) |=> rsp_valid)
      else $error("window item did not reach the result register");

endmodule
